FILE: hw/rtl/soht_pkg.sv
// Shared constants, codes and types of the size-ordered hole table.
package soht_pkg;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned PAGE_BYTES   = 4096;
  localparam int unsigned PAGE_W       = $clog2(PAGE_BYTES);
  localparam int unsigned IDX_W        = $clog2(DEPTH);
  localparam int unsigned CNT_W        = $clog2(DEPTH + 1);
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned CMP_W        = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  typedef enum logic [2:0] {
    MODE_INSERT   = 3'd0,
    MODE_DEL_IDX  = 3'd1,
    MODE_DEL_ADDR = 3'd2,
    MODE_FIND     = 3'd3,
    MODE_READ     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_CAPTURE,
    S_SHIFT_UP,
    S_PLACE,
    S_SHIFT_DN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] size;
  } entry_t;

  typedef struct packed {
    mode_e             mode;
    logic [31:0]       hole_addr;
    logic [31:0]       hole_size;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       request_size;
    logic              align;
  } req_t;

endpackage

FILE: hw/rtl/soht_ram.sv
// Hole table storage: one write port and one registered read port.
module soht_ram
  import soht_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/soht_cmp.sv
// Shared compare unit: tests one table entry against the pending request.
module soht_cmp
  import soht_pkg::*;
(
  input  req_t   req_i,
  input  entry_t ent_i,
  output logic   hit_o
);

  logic [PAGE_W-1:0] page_low;
  logic [PAGE_W:0]   offset;
  logic [31:0]       offset_ext;
  logic              fit;

  always_comb begin
    // Bytes from the header end up to the next page boundary, 1 to a full page.
    page_low   = PAGE_W'(ent_i.addr[PAGE_W-1:0] + PAGE_W'(HEADER_BYTES));
    offset     = (PAGE_W + 1)'(PAGE_BYTES) - (PAGE_W + 1)'(page_low);
    offset_ext = 32'(offset);
    if (req_i.align) begin
      fit = (ent_i.size >= offset_ext) &&
            ((ent_i.size - offset_ext) >= req_i.request_size);
    end else begin
      fit = ent_i.size >= req_i.request_size;
    end

    case (req_i.mode)
      MODE_INSERT:   hit_o = ent_i.size >= req_i.hole_size;
      MODE_DEL_ADDR: hit_o = ent_i.addr == req_i.hole_addr;
      MODE_FIND:     hit_o = fit;
      default:       hit_o = 1'b0;
    endcase
  end

endmodule

FILE: hw/rtl/size_ordered_hole_table.sv
// Top level of the size-ordered hole table with its request sequencer.
//
//  Channel   Dir  Transfer carries
//  s_axis    in   one request: tuser = mode, tdata = address, size, slot, need, align
//  m_axis    out  one result per request: tuser = status, tdata = slot, hole, count
//
// The search and the move of entries walk the table one entry per cycle through the
// single read port of the table memory, and every entry test uses the one compare unit.
// With n holes held, the time to a result grows with n for an insert, a delete by address,
// a search and a delete by index, but not for a read. A full table, a slot out of range or
// an unknown mode goes straight to the result. A new request transfer is taken only in the
// idle state, after the result of the last one. Reset empties the table at once by clearing
// the entry count; the stored entries are not cleared. A result waits in the output register
// while the block takes the next request; the sequencer stalls only when it finishes with
// that register still occupied.
module size_ordered_hole_table
  import soht_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,

  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // tdata from bit 0: hole_addr[31:0], hole_size[63:32], slot[69:64],
  // request_size[101:70], align[102], zero pad[103].
  input  logic [103:0]  s_axis_tdata,
  // tuser: mode[2:0].
  input  logic [2:0]    s_axis_tuser,

  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tdata from bit 0: found_slot[5:0], found_addr[37:6], found_size[69:38],
  // entry_count[76:70], zero pad[79:77].
  output logic [79:0]   m_axis_tdata,
  // tuser: status[1:0].
  output logic [1:0]    m_axis_tuser
);

  // Control state.
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              chk_vld_q, chk_vld_d;   // read data belongs to chk_idx_q
  logic              wb_vld_q, wb_vld_d;     // read data is due at wb_addr_q
  logic              out_vld_q, out_vld_d;

  // Working registers of the request in flight.
  req_t              req_q, req_d;
  logic [CNT_W-1:0]  scan_ptr_q, scan_ptr_d;
  logic [CNT_W-1:0]  chk_idx_q, chk_idx_d;
  logic [CNT_W-1:0]  k_q, k_d;               // position of the affected hole
  logic [CNT_W-1:0]  p_q, p_d;               // move pointer
  logic [IDX_W-1:0]  wb_addr_q, wb_addr_d;
  entry_t            ent_q, ent_d;
  status_e           res_status_q, res_status_d;

  // Output register.
  status_e           out_status_q, out_status_d;
  logic [5:0]        out_slot_q, out_slot_d;
  entry_t            out_ent_q, out_ent_d;
  logic [6:0]        out_count_q, out_count_d;

  // Memory and compare unit connections.
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  logic              hit;

  logic              issue, hit_now, slot_ok, full;
  logic [CNT_W-1:0]  p_dec, p_inc;

  soht_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  soht_cmp u_cmp (
    .req_i (req_q),
    .ent_i (ram_rdata),
    .hit_o (hit)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_count_q, out_ent_q.size, out_ent_q.addr, out_slot_q};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    chk_vld_d    = chk_vld_q;
    wb_vld_d     = wb_vld_q;
    out_vld_d    = out_vld_q && !m_axis_tready;
    req_d        = req_q;
    scan_ptr_d   = scan_ptr_q;
    chk_idx_d    = chk_idx_q;
    k_d          = k_q;
    p_d          = p_q;
    wb_addr_d    = wb_addr_q;
    ent_d        = ent_q;
    res_status_d = res_status_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_ent_d    = out_ent_q;
    out_count_d  = out_count_q;

    ram_we    = 1'b0;
    ram_waddr = wb_addr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = scan_ptr_q[IDX_W-1:0];

    issue   = scan_ptr_q < count_q;
    hit_now = chk_vld_q && hit;
    slot_ok = CMP_W'(s_axis_tdata[69:64]) < CMP_W'(count_q);
    full    = count_q >= CNT_W'(DEPTH);
    p_dec   = p_q - 1'b1;
    p_inc   = p_q + 1'b1;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_d.mode         = mode_e'(s_axis_tuser);
          req_d.hole_addr    = s_axis_tdata[31:0];
          req_d.hole_size    = s_axis_tdata[63:32];
          req_d.slot         = s_axis_tdata[69:64];
          req_d.request_size = s_axis_tdata[101:70];
          req_d.align        = s_axis_tdata[102];
          scan_ptr_d         = '0;
          chk_vld_d          = 1'b0;
          wb_vld_d           = 1'b0;
          res_status_d       = STAT_MISS;
          case (mode_e'(s_axis_tuser))
            MODE_INSERT: begin
              if (full) begin
                res_status_d = STAT_FULL;
                state_d      = S_DONE;
              end else begin
                state_d = S_SCAN;
              end
            end
            MODE_DEL_ADDR, MODE_FIND: state_d = S_SCAN;
            MODE_DEL_IDX, MODE_READ: begin
              if (slot_ok) begin
                k_d     = CNT_W'(s_axis_tdata[69:64]);
                state_d = S_FETCH;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      // Read one entry per cycle and test the one read the cycle before.
      S_SCAN: begin
        ram_re     = issue && !hit_now;
        chk_vld_d  = issue && !hit_now;
        chk_idx_d  = scan_ptr_q;
        scan_ptr_d = scan_ptr_q + 1'b1;
        if (hit_now || !issue) begin
          k_d   = hit_now ? chk_idx_q : count_q;
          ent_d = ram_rdata;
          case (req_q.mode)
            MODE_INSERT: begin
              // No hole of equal or larger size found means the new one goes at the end.
              p_d     = count_q;
              state_d = S_SHIFT_UP;
            end
            MODE_DEL_ADDR: begin
              p_d     = chk_idx_q;
              state_d = hit_now ? S_SHIFT_DN : S_DONE;
            end
            default: begin
              res_status_d = hit_now ? STAT_OK : STAT_MISS;
              state_d      = S_DONE;
            end
          endcase
        end
      end

      S_FETCH: begin
        ram_re    = 1'b1;
        ram_raddr = k_q[IDX_W-1:0];
        state_d   = S_CAPTURE;
      end

      S_CAPTURE: begin
        ent_d = ram_rdata;
        if (req_q.mode == MODE_DEL_IDX) begin
          p_d     = k_q;
          state_d = S_SHIFT_DN;
        end else begin
          res_status_d = STAT_OK;
          state_d      = S_DONE;
        end
      end

      // Move entries k..count-1 up by one, top first: read p-1, write p later.
      S_SHIFT_UP: begin
        ram_we = wb_vld_q;
        if (p_q > k_q) begin
          ram_re    = 1'b1;
          ram_raddr = p_dec[IDX_W-1:0];
          wb_vld_d  = 1'b1;
          wb_addr_d = p_q[IDX_W-1:0];
          p_d       = p_dec;
        end else begin
          wb_vld_d = 1'b0;
          state_d  = S_PLACE;
        end
      end

      S_PLACE: begin
        ram_we          = 1'b1;
        ram_waddr       = k_q[IDX_W-1:0];
        ram_wdata.addr  = req_q.hole_addr;
        ram_wdata.size  = req_q.hole_size;
        ent_d.addr      = req_q.hole_addr;
        ent_d.size      = req_q.hole_size;
        count_d         = count_q + 1'b1;
        res_status_d    = STAT_OK;
        state_d         = S_DONE;
      end

      // Close the gap at k: read p+1, write p later, bottom first.
      S_SHIFT_DN: begin
        ram_we = wb_vld_q;
        if (p_inc < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = p_inc[IDX_W-1:0];
          wb_vld_d  = 1'b1;
          wb_addr_d = p_q[IDX_W-1:0];
          p_d       = p_inc;
        end else begin
          wb_vld_d     = 1'b0;
          count_d      = count_q - 1'b1;
          res_status_d = STAT_OK;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_count_d  = 7'(count_q);
          if (res_status_q == STAT_OK) begin
            out_slot_d = 6'(k_q);
            out_ent_d  = ent_q;
          end else begin
            out_slot_d = '0;
            out_ent_d  = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      chk_vld_q <= 1'b0;
      wb_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      chk_vld_q <= chk_vld_d;
      wb_vld_q  <= wb_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    scan_ptr_q   <= scan_ptr_d;
    chk_idx_q    <= chk_idx_d;
    k_q          <= k_d;
    p_q          <= p_d;
    wb_addr_q    <= wb_addr_d;
    ent_q        <= ent_d;
    res_status_q <= res_status_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_ent_q    <= out_ent_d;
    out_count_q  <= out_count_d;
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench of the size-ordered hole table: directed and random requests.
module tb_top;
  import soht_pkg::*;

  // Batch flavors of the random part; each steers the table toward a region of its behavior.
  localparam int BATCH_FILL  = 0;
  localparam int BATCH_DRAIN = 1;
  localparam int BATCH_MIXED = 2;
  localparam int BATCH_LEN   = 35;
  localparam int NUM_BATCHES = 50;

  // Idle phases of the two channels.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  // A request's latency grows with the count.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] addr;
    logic [31:0] size;
    logic [5:0]  slot;
    logic [31:0] need;
    logic        align;
  } hole_req_t;

  typedef struct {
    status_e     status;
    logic [5:0]  slot;
    logic [31:0] addr;
    logic [31:0] size;
    logic [6:0]  count;
  } hole_result_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata = '0;
  logic [2:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [79:0]   m_axis_tdata;
  logic [1:0]    m_axis_tuser;

  // Shadow copy of the hole table, updated as each request transfer is accepted.
  logic [31:0]   shadow_addr [DEPTH];
  logic [31:0]   shadow_size [DEPTH];
  int unsigned   shadow_count = 0;

  hole_req_t     pending_reqs [$];
  hole_result_t  expected_results [$];

  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          req_fired = 1'b0;
  hole_req_t     drive_req;

  int            fail_count = 0;
  int            results_checked = 0;
  int            mode_seen [8];
  int            full_rejects = 0;
  int            aligned_hits = 0;
  int            peak_count = 0;

  logic [31:0]   addr_pool [16];
  logic [31:0]   size_pool [8];

  size_ordered_hole_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_failure(string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  // Bytes skipped so that the payload after the header starts on a page boundary.
  // The sum wraps at 32 bits, so the result always lies between 1 and a full page.
  function automatic logic [31:0] page_offset(logic [31:0] addr);
    logic [31:0] hdr_end;
    hdr_end = addr + 32'(HEADER_BYTES);
    return 32'(PAGE_BYTES) - {{(32 - PAGE_W){1'b0}}, hdr_end[PAGE_W-1:0]};
  endfunction

  function automatic logic hole_fits(logic [31:0] addr, logic [31:0] size,
                                     logic [31:0] need, logic align);
    logic [31:0] off;
    if (!align) return size >= need;
    off = page_offset(addr);
    // A hole smaller than its offset can never hold an aligned payload.
    if (size < off) return 1'b0;
    return (size - off) >= need;
  endfunction

  function automatic void remove_hole(int unsigned pos);
    for (int unsigned i = pos; i + 1 < shadow_count; i++) begin
      shadow_addr[i] = shadow_addr[i + 1];
      shadow_size[i] = shadow_size[i + 1];
    end
    shadow_count--;
  endfunction

  // Applies one request to the shadow table and returns the result the block must give.
  // Every result that is not ok carries zeros in slot, address and size.
  function automatic hole_result_t apply_hole_request(hole_req_t r);
    hole_result_t res;
    int unsigned  pos;
    res = '{STAT_MISS, 6'd0, 32'd0, 32'd0, 7'd0};
    pos = 0;
    case (r.mode)
      MODE_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          // New hole lands in front of the first hole of equal or larger size.
          while (pos < shadow_count && shadow_size[pos] < r.size) pos++;
          for (int unsigned i = shadow_count; i > pos; i--) begin
            shadow_addr[i] = shadow_addr[i - 1];
            shadow_size[i] = shadow_size[i - 1];
          end
          shadow_addr[pos] = r.addr;
          shadow_size[pos] = r.size;
          shadow_count++;
          res = '{STAT_OK, 6'(pos), r.addr, r.size, 7'd0};
        end
      end
      MODE_DEL_IDX: begin
        if (r.slot < shadow_count) begin
          res = '{STAT_OK, r.slot, shadow_addr[r.slot], shadow_size[r.slot], 7'd0};
          remove_hole(r.slot);
        end
      end
      MODE_DEL_ADDR: begin
        // With duplicate addresses the lowest position goes.
        while (pos < shadow_count && shadow_addr[pos] != r.addr) pos++;
        if (pos < shadow_count) begin
          res = '{STAT_OK, 6'(pos), r.addr, shadow_size[pos], 7'd0};
          remove_hole(pos);
        end
      end
      MODE_FIND: begin
        while (pos < shadow_count && !hole_fits(shadow_addr[pos], shadow_size[pos],
                                                r.need, r.align)) pos++;
        if (pos < shadow_count)
          res = '{STAT_OK, 6'(pos), shadow_addr[pos], shadow_size[pos], 7'd0};
      end
      MODE_READ: begin
        if (r.slot < shadow_count)
          res = '{STAT_OK, r.slot, shadow_addr[r.slot], shadow_size[r.slot], 7'd0};
      end
      default: ;  // Undefined modes leave the table alone and report a miss.
    endcase
    res.count = 7'(shadow_count);
    return res;
  endfunction

  function automatic void push_req(logic [2:0] mode, logic [31:0] addr, logic [31:0] size,
                                   logic [5:0] slot, logic [31:0] need, logic align);
    hole_req_t r;
    r = '{mode, addr, size, slot, need, align};
    pending_reqs.push_back(r);
  endfunction

  // Builds one batch of random requests. The table is idle when this runs, so the
  // shadow table is current and is used to aim deletes and searches at real holes.
  task automatic queue_random_batch(int kind, int n);
    hole_req_t   r;
    int          roll;
    int          est;
    int unsigned pick;
    logic [31:0] off;
    est = shadow_count;
    for (int k = 0; k < n; k++) begin
      // Unused fields carry random noise.
      r = '{3'($urandom_range(7, 0)), $urandom, $urandom, 6'($urandom), $urandom,
            1'($urandom)};
      roll = $urandom_range(99, 0);
      case (kind)
        BATCH_FILL: begin
          if (roll < 88)      r.mode = MODE_INSERT;
          else if (roll < 94) r.mode = MODE_FIND;
          else if (roll < 98) r.mode = MODE_READ;
          else                r.mode = 3'($urandom_range(7, 5));
        end
        BATCH_DRAIN: begin
          if (roll < 45)      r.mode = MODE_DEL_IDX;
          else if (roll < 85) r.mode = MODE_DEL_ADDR;
          else if (roll < 92) r.mode = MODE_FIND;
          else if (roll < 97) r.mode = MODE_READ;
          else                r.mode = MODE_INSERT;
        end
        default: begin
          if (roll < 30)      r.mode = MODE_INSERT;
          else if (roll < 45) r.mode = MODE_DEL_IDX;
          else if (roll < 60) r.mode = MODE_DEL_ADDR;
          else if (roll < 85) r.mode = MODE_FIND;
          else if (roll < 95) r.mode = MODE_READ;
          else                r.mode = 3'($urandom_range(7, 5));
        end
      endcase

      // Address: pool values give duplicates and delete hits, pages near the header
      // boundary stress the aligned search.
      roll = $urandom_range(99, 0);
      if (roll < 40)
        r.addr = addr_pool[$urandom_range(15, 0)];
      else if (roll < 60)
        r.addr = ($urandom & 32'hFFFF_F000) | (32'hFF0 + 32'($urandom_range(8, 0)));
      if (r.mode == MODE_DEL_ADDR && shadow_count > 0 && $urandom_range(99, 0) < 70)
        r.addr = shadow_addr[$urandom_range(shadow_count - 1, 0)];

      // Size: small values and pool values give ties, extremes check the compare.
      roll = $urandom_range(99, 0);
      if (roll < 40)      r.size = $urandom_range(8192, 0);
      else if (roll < 60) r.size = size_pool[$urandom_range(7, 0)];
      else if (roll < 68) r.size = 32'd0;
      else if (roll < 75) r.size = 32'hFFFF_FFFF;

      // Slot: mostly within the estimated count, one past it included.
      if ($urandom_range(99, 0) < 70)
        r.slot = 6'($urandom_range((est > 63) ? 63 : est, 0));

      // Need: often placed right at the edge of a held hole's capacity.
      roll = $urandom_range(99, 0);
      if (roll < 30) begin
        r.need = $urandom_range(8192, 0);
      end else if (roll < 60 && shadow_count > 0) begin
        pick = $urandom_range(shadow_count - 1, 0);
        off = page_offset(shadow_addr[pick]);
        if (r.align && shadow_size[pick] >= off)
          r.need = shadow_size[pick] - off + 32'($urandom_range(2, 0)) - 32'd1;
        else
          r.need = shadow_size[pick] + 32'($urandom_range(2, 0)) - 32'd1;
      end else if (roll < 70) begin
        r.need = 32'd0;
      end else if (roll < 80) begin
        r.need = 32'hFFFF_FFFF;
      end

      case (r.mode)
        MODE_INSERT:                if (est < DEPTH) est++;
        MODE_DEL_IDX, MODE_DEL_ADDR: if (est > 0) est--;
        default: ;
      endcase
      pending_reqs.push_back(r);
    end
  endtask

  // Holds the stimulus back until every accepted request has produced its result.
  task automatic wait_table_idle();
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  // Request driver: changes the slave-side inputs on the falling edge. A request stays
  // on the bus until a transfer takes it; a new one follows only after that transfer.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || req_fired) begin
        if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          drive_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= drive_req.mode;
          s_axis_tdata  <= {1'b0, drive_req.align, drive_req.need, drive_req.slot,
                            drive_req.size, drive_req.addr};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Monitor: on each rising edge it predicts from an accepted request transfer and
  // checks an accepted result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    hole_req_t    seen_req;
    hole_result_t want;
    hole_result_t want_done;
    logic [5:0]   got_slot;
    logic [31:0]  got_addr;
    logic [31:0]  got_size;
    logic [6:0]   got_count;
    req_fired <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      seen_req = '{s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                   s_axis_tdata[69:64], s_axis_tdata[101:70], s_axis_tdata[102]};
      want_done = apply_hole_request(seen_req);
      expected_results.push_back(want_done);
      mode_seen[seen_req.mode]++;
      if (want_done.status == STAT_FULL) full_rejects++;
      if (seen_req.mode == MODE_FIND && seen_req.align && want_done.status == STAT_OK)
        aligned_hits++;
      if (int'(want_done.count) > peak_count) peak_count = want_done.count;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_slot  = m_axis_tdata[5:0];
      got_addr  = m_axis_tdata[37:6];
      got_size  = m_axis_tdata[69:38];
      got_count = m_axis_tdata[76:70];
      if (expected_results.size() == 0) begin
        report_failure($sformatf("result with nothing outstanding: status %0d slot %0d",
                                 m_axis_tuser, got_slot));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status)
          report_failure($sformatf("result %0d status: got %0d, expected %0d",
                                   results_checked, m_axis_tuser, want.status));
        if (got_slot !== want.slot)
          report_failure($sformatf("result %0d slot: got %0d, expected %0d",
                                   results_checked, got_slot, want.slot));
        if (got_addr !== want.addr)
          report_failure($sformatf("result %0d address: got %h, expected %h",
                                   results_checked, got_addr, want.addr));
        if (got_size !== want.size)
          report_failure($sformatf("result %0d size: got %h, expected %h",
                                   results_checked, got_size, want.size));
        if (got_count !== want.count)
          report_failure($sformatf("result %0d count: got %0d, expected %0d",
                                   results_checked, got_count, want.count));
      end
      results_checked++;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'd0;
    addr_pool[1] = 32'hFFFF_FFFF;
    // Addresses whose header ends exactly on a page boundary, one of them wrapping, and one just past it.
    addr_pool[2] = 32'hFFFF_FFF4;
    addr_pool[3] = ($urandom & 32'hFFFF_F000) | 32'hFF4;
    addr_pool[4] = ($urandom & 32'hFFFF_F000) | 32'hFF5;
    size_pool = '{32'd0, 32'd1, 32'd4095, 32'd4096, 32'd4097, 32'd8192, 32'd100, $urandom};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Requests on an empty table all miss; undefined modes miss too.
    push_req(MODE_READ,     32'd0, 32'd0, 6'd0, 32'd0, 1'b0);
    push_req(MODE_DEL_IDX,  32'd0, 32'd0, 6'd0, 32'd0, 1'b0);
    push_req(MODE_DEL_ADDR, 32'd0, 32'd0, 6'd0, 32'd0, 1'b0);
    push_req(MODE_FIND,     32'd0, 32'd0, 6'd0, 32'd0, 1'b0);
    for (int m = 5; m < 8; m++)
      push_req(3'(m), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1);
    // Inserts: size extremes, equal sizes, a repeated address, a wrapping header.
    push_req(MODE_INSERT, 32'd0,         32'd0,         6'd0, 32'd0, 1'b0);
    push_req(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 32'd0, 1'b0);
    push_req(MODE_INSERT, 32'h0000_0FF4, 32'd4096,      6'd0, 32'd0, 1'b0);
    push_req(MODE_INSERT, 32'h0001_2345, 32'd100,       6'd0, 32'd0, 1'b0);
    push_req(MODE_INSERT, 32'h000A_BCDE, 32'd100,       6'd0, 32'd0, 1'b0);
    push_req(MODE_INSERT, 32'h0000_0FF4, 32'd5000,      6'd0, 32'd0, 1'b0);
    push_req(MODE_INSERT, 32'hFFFF_FFF4, 32'd4096,      6'd0, 32'd0, 1'b0);
    // Searches: plain and aligned, with a full-page offset on an aligned header.
    push_req(MODE_FIND, 32'd0, 32'd0, 6'd0, 32'd0,         1'b0);
    push_req(MODE_FIND, 32'd0, 32'd0, 6'd0, 32'hFFFF_FFFF, 1'b0);
    push_req(MODE_FIND, 32'd0, 32'd0, 6'd0, 32'd0,         1'b1);
    push_req(MODE_FIND, 32'd0, 32'd0, 6'd0, 32'd1,         1'b1);
    push_req(MODE_FIND, 32'd0, 32'd0, 6'd0, 32'hFFFF_FFFF, 1'b1);
    // Reads and deletes in and out of range, and a delete of a duplicated address.
    push_req(MODE_READ,     32'd0,         32'd0, 6'd63, 32'd0, 1'b0);
    push_req(MODE_READ,     32'd0,         32'd0, 6'd2,  32'd0, 1'b0);
    push_req(MODE_DEL_ADDR, 32'h0000_0FF4, 32'd0, 6'd0,  32'd0, 1'b0);
    push_req(MODE_DEL_IDX,  32'd0,         32'd0, 6'd5,  32'd0, 1'b0);
    push_req(MODE_DEL_IDX,  32'd0,         32'd0, 6'd0,  32'd0, 1'b0);
    push_req(MODE_DEL_IDX,  32'd0,         32'd0, 6'd40, 32'd0, 1'b0);

    // Random part: batches cycle through fill, drain and mixed flavors and through
    // the idle phases. Between batches the sender waits for every outstanding result.
    for (int b = 0; b < NUM_BATCHES; b++) begin
      wait_table_idle();
      case (b % 4)
        IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        IDLE_SEND: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default:   begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case (b % 8)
        0, 1, 2: queue_random_batch(BATCH_FILL, BATCH_LEN);
        3, 4, 5: queue_random_batch(BATCH_DRAIN, BATCH_LEN);
        default: queue_random_batch(BATCH_MIXED, BATCH_LEN);
      endcase
    end

    wait_table_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("Checked %0d results: %0d inserts, %0d index deletes, %0d address deletes,",
             results_checked, mode_seen[MODE_INSERT], mode_seen[MODE_DEL_IDX],
             mode_seen[MODE_DEL_ADDR]);
    $display("%0d searches (%0d aligned hits), %0d reads, %0d bad modes, %0d full, peak %0d",
             mode_seen[MODE_FIND], aligned_hits, mode_seen[MODE_READ],
             mode_seen[5] + mode_seen[6] + mode_seen[7], full_rejects, peak_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("Timeout with %0d requests queued and %0d results outstanding",
             pending_reqs.size(), expected_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
